@@ rtl/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mpsp_pkg.sv @@
// ----------------------------------------------------------------------------
// mpsp_pkg
// Word types and register map of the mean point sphere projection block.
// ----------------------------------------------------------------------------
package mpsp_pkg;

    // Input word: one tracked vehicle.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [7:0]         detection_count;
        logic               has_position;
        logic               last_item;
    } t_in;

    // Output word: projected mean point.
    typedef struct packed {
        logic signed [31:0] proj_x;
        logic signed [31:0] proj_y;
        logic signed [31:0] proj_z;
        logic               point_valid;
    } t_out;

    // Register indexes (byte address / 4).
    localparam logic [1:0] REG_RADIUS   = 2'd0;
    localparam logic [1:0] REG_CENTER_X = 2'd1;
    localparam logic [1:0] REG_CENTER_Y = 2'd2;
    localparam logic [1:0] REG_CENTER_Z = 2'd3;

    localparam logic [30:0] RADIUS_RESET = 31'd655360;

    // Width of the shared divider and square root datapath.
    localparam int WIDE_W = 64;
    localparam int DIV_STEPS_W = 6;

endpackage

@@ rtl/mean_point_sphere_projection.sv @@
// Non-last words are accepted as they arrive; a last word starts the result
// sequence (three 64-bit mean divides, normalize shifts, a 32-bit square
// root and three 64-bit projection divides on one shared divider).
// Throughput: one word per cycle inside a set; no input until the result loads.
// Reset: synchronous active low; clears sums, count and control, and loads
// the register reset values (radius 10.0, center at the origin).
// ----------------------------------------------------------------------------
// mean_point_sphere_projection
// Averages qualifying vehicle positions and projects the mean radially onto
// a configured sphere, using one shared divider, multiplier and root step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mean_point_sphere_projection
    import mpsp_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ACC_W = 32 + $clog2(MAX_ENTRIES);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_MEAN_LD  = 4'd2;
    localparam logic [3:0] S_MEAN_DIV = 4'd3;
    localparam logic [3:0] S_OFFSET   = 4'd4;
    localparam logic [3:0] S_NORM     = 4'd5;
    localparam logic [3:0] S_SQ_MUL   = 4'd6;
    localparam logic [3:0] S_SQ_ACC   = 4'd7;
    localparam logic [3:0] S_SQRT     = 4'd8;
    localparam logic [3:0] S_PR_MUL   = 4'd9;
    localparam logic [3:0] S_PR_LD    = 4'd10;
    localparam logic [3:0] S_PR_DIV   = 4'd11;
    localparam logic [3:0] S_PR_FIN   = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    // Configuration registers.
    logic [30:0]        r_radius;
    logic signed [31:0] r_ctr [3];

    // Set accumulation.
    logic signed [ACC_W-1:0] r_acc [3];
    logic [CNT_W-1:0]        r_cnt;

    // Sequencer and per-axis working values.
    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic [1:0]         r_axis;
    logic [31:0]        r_mag [3];
    logic               r_neg [3];
    logic signed [31:0] r_res [3];
    logic               r_valid;

    // Shared units.
    logic [WIDE_W-1:0]      r_prod;
    logic [WIDE_W-1:0]      r_sum;
    logic [WIDE_W-1:0]      r_div_num;
    logic [31:0]            r_div_den;
    logic [31:0]            r_div_rem;
    logic [DIV_STEPS_W-1:0] r_div_cnt;
    logic [WIDE_W-1:0]      r_sq_v;
    logic [WIDE_W-1:0]      r_sq_res;
    logic [WIDE_W-1:0]      r_sq_bit;
    logic [31:0]            r_norm;

    // Output register.
    t_out r_out;
    logic r_out_valid;

    logic in_acc;
    logic qualifies;
    logic cfg_wr;
    logic out_load;

    assign pready      = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign qualifies   = (i_in_data.detection_count == 8'd1) && i_in_data.has_position
                         && (r_cnt < CNT_W'(MAX_ENTRIES));
    assign cfg_wr      = psel && penable && pwrite;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Register read mux.
    always_comb begin
        unique case (paddr[3:2])
            REG_RADIUS:   prdata = {1'b0, r_radius};
            REG_CENTER_X: prdata = r_ctr[0];
            REG_CENTER_Y: prdata = r_ctr[1];
            REG_CENTER_Z: prdata = r_ctr[2];
            default:      prdata = 32'd0;
        endcase
    end

    // Largest of the three offset magnitudes.
    logic [31:0] mag_max;
    always_comb begin
        mag_max = r_mag[0];
        if (r_mag[1] > mag_max) mag_max = r_mag[1];
        if (r_mag[2] > mag_max) mag_max = r_mag[2];
    end

    // Divider step: one quotient bit per cycle.
    logic [32:0] div_rem_sh;
    logic        div_ge;
    assign div_rem_sh = {r_div_rem, r_div_num[WIDE_W-1]};
    assign div_ge     = div_rem_sh >= {1'b0, r_div_den};

    // Square root step: two radicand bits per cycle.
    logic [WIDE_W-1:0] sq_trial;
    logic              sq_ge;
    assign sq_trial = r_sq_res + r_sq_bit;
    assign sq_ge    = r_sq_v >= sq_trial;

    // Shared multiplier operands.
    logic [31:0]       mul_a;
    logic [WIDE_W-1:0] mul_p;
    assign mul_a = (r_state == S_SQ_MUL) ? r_mag[r_axis] : {1'b0, r_radius};
    assign mul_p = mul_a * r_mag[r_axis];

    // Mean magnitude numerator, before the half-count rounding is added.
    logic [ACC_W-1:0] acc_mag;
    assign acc_mag = r_acc[r_axis][ACC_W-1] ? ACC_W'(-r_acc[r_axis]) : r_acc[r_axis];

    // Offset of the mean from the center.
    logic signed [33:0] mean_s;
    logic signed [33:0] off_s;
    assign mean_s = r_acc[r_axis][ACC_W-1] ? -$signed({2'b00, r_div_num[31:0]})
                                           :  $signed({2'b00, r_div_num[31:0]});
    assign off_s  = mean_s - 34'(r_ctr[r_axis]);

    // Projected component with saturation.
    logic signed [33:0] proj_d;
    logic signed [33:0] proj_s;
    logic signed [31:0] proj_sat;
    assign proj_d = r_neg[r_axis] ? -$signed({2'b00, r_div_num[31:0]})
                                  :  $signed({2'b00, r_div_num[31:0]});
    assign proj_s = 34'(r_ctr[r_axis]) + proj_d;
    always_comb begin
        if (proj_s > 34'sd2147483647) begin
            proj_sat = 32'sh7FFFFFFF;
        end else if (proj_s < -34'sd2147483648) begin
            proj_sat = 32'sh80000000;
        end else begin
            proj_sat = proj_s[31:0];
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (in_acc && i_in_data.last_item) n_state = S_START;
            S_START:    n_state = (r_cnt == '0) ? S_DONE : S_MEAN_LD;
            S_MEAN_LD:  n_state = S_MEAN_DIV;
            S_MEAN_DIV: if (r_div_cnt == '1) n_state = S_OFFSET;
            S_OFFSET:   n_state = (r_axis == 2'd2) ? S_NORM : S_MEAN_LD;
            S_NORM: begin
                if (mag_max == 32'd0) begin
                    n_state = S_DONE;
                end else if (mag_max[31:30] == 2'b01) begin
                    n_state = S_SQ_MUL;
                end
            end
            S_SQ_MUL:   n_state = S_SQ_ACC;
            S_SQ_ACC:   n_state = (r_axis == 2'd2) ? S_SQRT : S_SQ_MUL;
            S_SQRT:     if (r_sq_bit[0]) n_state = S_PR_MUL;
            S_PR_MUL:   n_state = S_PR_LD;
            S_PR_LD:    n_state = S_PR_DIV;
            S_PR_DIV:   if (r_div_cnt == '1) n_state = S_PR_FIN;
            S_PR_FIN:   n_state = (r_axis == 2'd2) ? S_DONE : S_PR_MUL;
            S_DONE:     if (out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 2'd0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_valid     <= 1'b0;
            r_radius    <= RADIUS_RESET;
            for (int i = 0; i < 3; i++) begin
                r_ctr[i] <= 32'sd0;
                r_acc[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            // Configuration writes.
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_RADIUS:   r_radius <= pwdata[30:0];
                    REG_CENTER_X: r_ctr[0] <= pwdata;
                    REG_CENTER_Y: r_ctr[1] <= pwdata;
                    REG_CENTER_Z: r_ctr[2] <= pwdata;
                    default:      r_radius <= r_radius;
                endcase
            end

            // Accumulate a qualifying vehicle.
            if (in_acc && qualifies) begin
                r_acc[0] <= r_acc[0] + ACC_W'(i_in_data.pos_x);
                r_acc[1] <= r_acc[1] + ACC_W'(i_in_data.pos_y);
                r_acc[2] <= r_acc[2] + ACC_W'(i_in_data.pos_z);
                r_cnt    <= r_cnt + 1'b1;
            end

            // Axis walk and result flag.
            case (r_state) inside
                S_START: begin
                    r_axis  <= 2'd0;
                    r_valid <= 1'b0;
                end
                S_OFFSET, S_SQ_ACC, S_PR_FIN: begin
                    r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                    if (r_state == S_PR_FIN && r_axis == 2'd2) r_valid <= 1'b1;
                end
                default: r_axis <= r_axis;
            endcase

            // Hand the result to the output register and clear the set.
            if (out_load) begin
                r_out_valid <= 1'b1;
                for (int i = 0; i < 3; i++) r_acc[i] <= '0;
                r_cnt <= '0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state) inside
            S_START: begin
                for (int i = 0; i < 3; i++) r_res[i] <= 32'sd0;
            end
            S_MEAN_LD: begin
                r_div_num <= WIDE_W'(acc_mag) + WIDE_W'(r_cnt >> 1);
                r_div_den <= 32'(r_cnt);
                r_div_rem <= 32'd0;
                r_div_cnt <= '0;
            end
            S_MEAN_DIV, S_PR_DIV: begin
                r_div_num <= {r_div_num[WIDE_W-2:0], div_ge};
                r_div_rem <= div_ge ? 32'(div_rem_sh - {1'b0, r_div_den})
                                    : div_rem_sh[31:0];
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            S_OFFSET: begin
                r_neg[r_axis] <= off_s[33];
                r_mag[r_axis] <= off_s[33] ? 32'(-off_s) : off_s[31:0];
            end
            S_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    if (mag_max[31]) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end else if (!mag_max[30]) begin
                        r_mag[i] <= r_mag[i] << 1;
                    end
                end
                r_sum <= '0;
            end
            S_SQ_MUL, S_PR_MUL: r_prod <= mul_p;
            S_SQ_ACC: begin
                r_sum    <= r_sum + r_prod;
                r_sq_v   <= r_sum + r_prod;
                r_sq_res <= '0;
                r_sq_bit <= WIDE_W'(1) << (WIDE_W - 2);
            end
            S_SQRT: begin
                r_sq_v   <= sq_ge ? r_sq_v - sq_trial : r_sq_v;
                r_sq_res <= sq_ge ? (r_sq_res >> 1) + r_sq_bit : r_sq_res >> 1;
                r_sq_bit <= r_sq_bit >> 2;
                r_norm   <= sq_ge ? 32'((r_sq_res >> 1) + r_sq_bit) : 32'(r_sq_res >> 1);
            end
            S_PR_LD: begin
                r_div_num <= r_prod + WIDE_W'(r_norm >> 1);
                r_div_den <= r_norm;
                r_div_rem <= 32'd0;
                r_div_cnt <= '0;
            end
            S_PR_FIN: r_res[r_axis] <= proj_sat;
            S_DONE: begin
                if (out_load) begin
                    r_out.proj_x      <= r_valid ? r_res[0] : 32'sd0;
                    r_out.proj_y      <= r_valid ? r_res[1] : 32'sd0;
                    r_out.proj_z      <= r_valid ? r_res[2] : 32'sd0;
                    r_out.point_valid <= r_valid;
                end
            end
            default: r_norm <= r_norm;
        endcase
    end

    // Checks.
    `ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(MAX_ENTRIES), "count above limit")
    `ASSERT_IMPL(a_invalid_zero, i_clk, i_rst_n, r_out_valid && !r_out.point_valid, r_out.proj_x == 32'sd0 && r_out.proj_y == 32'sd0 && r_out.proj_z == 32'sd0, "invalid word not zero")
    `ASSERT_IMPL(a_norm_range, i_clk, i_rst_n, r_state == S_SQ_MUL, mag_max[31:30] == 2'b01, "normalize out of range")
    `ASSERT_NEXT(a_set_clear, i_clk, i_rst_n, out_load, r_cnt == '0 && r_state == S_IDLE, "set not cleared")

endmodule

@@ tb/mpsp_projection_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsp_projection_checker
// Watches the vehicle, result and register channels of the mean point sphere
// projection block. It keeps its own sums and register copies, predicts each
// projected point, and compares every result word against the oldest one.
// ----------------------------------------------------------------------------
module mpsp_projection_checker
    import mpsp_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out        i_out_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    // Shadow copies of the registers and the running sums.
    logic [30:0]        radius;
    logic signed [63:0] center [3];
    logic signed [63:0] pos_sum [3];
    int                 vehicle_count;
    t_out               projected_points [$];

    assign o_pending = projected_points.size();

    // Rounded mean, ties away from zero.
    function automatic logic signed [63:0] mean_of(logic signed [63:0] total, int cnt);
        logic [63:0] mag;
        logic [63:0] q;
        mag = total < 0 ? -total : total;
        q = (mag + cnt / 2) / cnt;
        return total < 0 ? -$signed(q) : $signed(q);
    endfunction

    // Floor of the square root, bit by bit.
    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Projects the mean of the current set onto the sphere.
    function automatic t_out project_mean();
        t_out               r;
        logic signed [63:0] off [3];
        logic [63:0]        mag [3];
        logic [63:0]        m;
        logic [63:0]        sumsq;
        logic [63:0]        norm;
        logic [63:0]        q;
        logic signed [63:0] p;
        r = '0;
        if (vehicle_count == 0) return r;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            off[i] = mean_of(pos_sum[i], vehicle_count) - center[i];
            mag[i] = off[i] < 0 ? -off[i] : off[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return r;
        while (m < (64'd1 << 30)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        while (m >= (64'd1 << 31)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        sumsq = 0;
        for (int i = 0; i < 3; i++) sumsq += mag[i] * mag[i];
        norm = root_floor(sumsq);
        for (int i = 0; i < 3; i++) begin
            q = ({33'd0, radius} * mag[i] + norm / 2) / norm;
            p = center[i] + (off[i] < 0 ? -$signed(q) : $signed(q));
            if (p > 64'sd2147483647) p = 64'sd2147483647;
            if (p < -64'sd2147483648) p = -64'sd2147483648;
            if (i == 0) r.proj_x = p[31:0];
            if (i == 1) r.proj_y = p[31:0];
            if (i == 2) r.proj_z = p[31:0];
        end
        r.point_valid = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        int   errs;
        errs = 0;
        if (!i_rst_n) begin
            radius <= RADIUS_RESET;
            for (int i = 0; i < 3; i++) begin
                center[i] <= 0;
                pos_sum[i] = 0;
            end
            vehicle_count = 0;
            projected_points.delete();
            o_fail_count <= 0;
        end else begin
            // Register writes update the shadow copies.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_RADIUS:   radius <= i_pwdata[30:0];
                    REG_CENTER_X: center[0] <= $signed(i_pwdata);
                    REG_CENTER_Y: center[1] <= $signed(i_pwdata);
                    REG_CENTER_Z: center[2] <= $signed(i_pwdata);
                    default: ;
                endcase
            end
            // Accepted vehicle word: accumulate, and predict on the last one.
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.detection_count == 8'd1 && i_in_data.has_position &&
                        vehicle_count < MAX_ENTRIES) begin
                    pos_sum[0] = pos_sum[0] + i_in_data.pos_x;
                    pos_sum[1] = pos_sum[1] + i_in_data.pos_y;
                    pos_sum[2] = pos_sum[2] + i_in_data.pos_z;
                    vehicle_count = vehicle_count + 1;
                end
                if (i_in_data.last_item) begin
                    projected_points.insert(projected_points.size(), project_mean());
                    for (int i = 0; i < 3; i++) pos_sum[i] = 0;
                    vehicle_count = 0;
                end
            end
            // Accepted result word: compare with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (projected_points.size() == 0) begin
                    $error("unexpected result word");
                    errs++;
                end else begin
                    want = projected_points.pop_front();
                    if (want.proj_x !== i_out_data.proj_x) begin
                        $error("proj_x: expected %0d, actual %0d", want.proj_x,
                               i_out_data.proj_x);
                        errs++;
                    end
                    if (want.proj_y !== i_out_data.proj_y) begin
                        $error("proj_y: expected %0d, actual %0d", want.proj_y,
                               i_out_data.proj_y);
                        errs++;
                    end
                    if (want.proj_z !== i_out_data.proj_z) begin
                        $error("proj_z: expected %0d, actual %0d", want.proj_z,
                               i_out_data.proj_z);
                        errs++;
                    end
                    if (want.point_valid !== i_out_data.point_valid) begin
                        $error("point_valid: expected %0d, actual %0d",
                               want.point_valid, i_out_data.point_valid);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

@@ tb/mean_point_sphere_projection_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_point_sphere_projection_tb
// Drives sets of vehicle words and register settings into the block, with
// random bursts on the input and random stalls on the output; the checker
// predicts and compares the projected points.
// ----------------------------------------------------------------------------
module mean_point_sphere_projection_tb;
    import mpsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          burst_left;
    int          stall_mode;
    int          stall_left;
    int          words_sent;

    mean_point_sphere_projection uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    mpsp_projection_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_data(o_out_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("mean_point_sphere_projection test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side stalls: switches between always ready, random and long stalls.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 400);
        end
        stall_left = stall_left - 1;
        case (stall_mode)
            0: i_out_ready = 1'b1;
            1: i_out_ready = $urandom_range(0, 1);
            default: i_out_ready = ($urandom_range(0, 7) == 0);
        endcase
    end

    // One register write: setup cycle, then access cycle.
    task automatic write_register(logic [1:0] index, logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {index, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Waits until every result is in, then lets the block settle.
    task automatic drain_results();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_sphere(logic [30:0] r, logic [31:0] cx, logic [31:0] cy,
                              logic [31:0] cz);
        write_register(REG_RADIUS, {1'b0, r});
        write_register(REG_CENTER_X, cx);
        write_register(REG_CENTER_Y, cy);
        write_register(REG_CENTER_Z, cz);
    endtask

    // Sends one vehicle word, with a random gap between bursts.
    task automatic send_vehicle(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                logic [7:0] dets, logic has_pos, logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        i_in_valid = 1'b1;
        i_in_data.pos_x = x;
        i_in_data.pos_y = y;
        i_in_data.pos_z = z;
        i_in_data.detection_count = dets;
        i_in_data.has_position = has_pos;
        i_in_data.last_item = last;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return $urandom_range(0, 200000) - 100000;
            default: return $urandom_range(0, 2000000) - 1000000;
        endcase
    endfunction

    // A set of random vehicles; most qualify.
    task automatic send_random_set(int n);
        logic [7:0] dets;
        for (int k = 0; k < n; k++) begin
            dets = ($urandom_range(0, 9) < 7) ? 8'd1 : 8'($urandom());
            send_vehicle(random_coord(), random_coord(), random_coord(), dets,
                         $urandom_range(0, 4) != 0, k == n - 1);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        words_sent = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed sets at the reset register values.
        send_vehicle(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 8'd1, 1'b1, 1'b1);
        send_vehicle(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 8'd1, 1'b1, 1'b1);
        // Nothing qualifies: wrong counts and unknown position.
        send_vehicle(32'h0001_0000, 32'd5, 32'd7, 8'd0, 1'b1, 1'b0);
        send_vehicle(32'h0002_0000, 32'd5, 32'd7, 8'd2, 1'b1, 1'b0);
        send_vehicle(32'h0003_0000, 32'd5, 32'd7, 8'd255, 1'b1, 1'b0);
        send_vehicle(32'h0004_0000, 32'd5, 32'd7, 8'd1, 1'b0, 1'b1);
        // Mean equals the center.
        send_vehicle(32'h0001_0000, 32'd0, 32'd0, 8'd1, 1'b1, 1'b0);
        send_vehicle(32'hFFFF_0000, 32'd0, 32'd0, 8'd1, 1'b1, 1'b1);
        // Rounding ties on the mean, last word not qualifying.
        send_vehicle(32'd1, 32'hFFFF_FFFF, 32'd3, 8'd1, 1'b1, 1'b0);
        send_vehicle(32'd2, 32'hFFFF_FFFE, 32'd0, 8'd1, 1'b1, 1'b0);
        send_vehicle(32'd9, 32'd9, 32'd9, 8'd3, 1'b1, 1'b1);
        drain_results();

        // Extreme spheres; large radius with far centers saturates.
        set_sphere(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_vehicle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'd1, 1'b1, 1'b1);
        send_vehicle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd1, 1'b1, 1'b1);
        send_vehicle(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 8'd1, 1'b1, 1'b1);
        drain_results();
        set_sphere(31'd0, 32'h0010_0000, 32'hFFF0_0000, 32'd0);
        send_vehicle(32'd0, 32'd0, 32'd0, 8'd1, 1'b1, 1'b1);
        // Long set of more words than the limit; qualifying words past it are ignored.
        send_random_set(70);
        drain_results();

        // Random phases, each with its own sphere.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: set_sphere(31'($urandom_range(0, 32'h00FF_FFFF)),
                              32'($urandom_range(0, 2000000)) - 1000000,
                              32'($urandom_range(0, 2000000)) - 1000000,
                              32'($urandom_range(0, 2000000)) - 1000000);
                1: set_sphere(31'($urandom()), $urandom(), $urandom(), $urandom());
                2: set_sphere(31'd655360, 32'd0, 32'd0, 32'd0);
                default: set_sphere(31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                    32'h8000_0000);
            endcase
            while (words_sent < 30 + (phase + 1) * 137) begin
                if ($urandom_range(0, 19) == 0) send_random_set($urandom_range(60, 70));
                else send_random_set($urandom_range(1, 8));
            end
            drain_results();
        end

        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("mean_point_sphere_projection test passed");
        end else begin
            $display("mean_point_sphere_projection test failed");
        end
        $finish;
    end

endmodule
